[design/ptts_pkg.sv]
package ptts_pkg;
	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W = 4;

	typedef enum logic [1:0] {
		OUT_LOAD = 2'd0,
		OUT_RAN = 2'd1,
		OUT_IDLE = 2'd2,
		OUT_OVERFLOW = 2'd3
	} outcome_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [15:0] burst;
		logic [15:0] period;
		logic [15:0] remaining;
		logic [31:0] release_t;
		logic [31:0] deadline;
	} slot_t;

	typedef struct packed {
		logic        found;
		logic [31:0] key;
		logic [15:0] id;
	} best_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage

[design/periodic_task_tick_scheduler.sv]
// Channel | Beat signals       | Payload
// in      | in_valid/in_ready  | command, slot_index, task_id, burst_length, period_length
// out     | out_valid/out_ready| outcome, ran_id, tick_time
// cfg     | cfg_we             | cfg_data (policy_mode)
// The slots sit in a ring of sixteen cells that rotates one place per cycle while busy.
// A tick laps the ring to find the winner, then again to run it (not on overflow).
// A load takes one lap of the ring; the slot is written as it passes the head.
// The result waits in an output register; a stall holds it and the next beat.
// Reset clears the valid bits, the time counter and the mode.
module periodic_task_tick_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  slot_index,
	input  logic [15:0] task_id,
	input  logic [15:0] burst_length,
	input  logic [15:0] period_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  outcome,
	output logic [15:0] ran_id,
	output logic [31:0] tick_time
);
	import ptts_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RUN, ST_LOAD} state_t;

	state_t              state_q;
	logic                edf_q;
	logic [31:0]         time_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]   tgt_q;
	logic [TASK_SLOTS-1:0] valid_q;
	slot_t               ld_q;
	best_t               best_q;
	logic [SLOT_W-1:0]   best_pos_q;
	slot_t               cells [TASK_SLOTS];
	slot_t               head;
	logic                shift;
	logic                head_valid;
	logic                ready_k;
	logic [31:0]         key;
	logic                go;

	assign shift = state_q != ST_IDLE;
	assign in_ready = state_q == ST_IDLE && !out_valid;
	assign go = in_valid && in_ready;

	always_comb begin
		head = cells[TASK_SLOTS-1];
		head.valid = valid_q[cnt_q];
	end

	genvar g;
	for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
		ptts_cell u_cell (
			.clk       (clk),
			.shift     (shift),
			.load_here (g == 0 && state_q == ST_LOAD && cnt_q == tgt_q),
			.load_data (ld_q),
			.run_here  (g == 0 && state_q == ST_RUN && best_q.found && cnt_q == best_pos_q),
			.edf       (edf_q),
			.prev      ((g == 0) ? head : cells[(g == 0) ? 0 : g-1]),
			.slot      (cells[g])
		);
	end

	assign head_valid = valid_q[cnt_q];
	assign ready_k = head_valid && head.release_t <= time_q && head.remaining != 16'd0;
	assign key = edf_q ? head.deadline : {16'd0, head.period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edf_q <= 1'b0;
			time_q <= '0;
			cnt_q <= '0;
			valid_q <= '0;
			out_valid <= 1'b0;
			best_q <= '0;
		end else begin
			if (cfg_we) begin
				edf_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (shift) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						ld_q.valid <= 1'b1;
						ld_q.id <= task_id;
						ld_q.burst <= burst_length;
						ld_q.period <= period_length;
						ld_q.remaining <= burst_length;
						ld_q.release_t <= '0;
						ld_q.deadline <= {16'd0, period_length};
						tgt_q <= slot_index;
						tick_time <= time_q;
						ran_id <= '0;
						best_q <= '0;
						if (!command) begin
							state_q <= ST_LOAD;
						end else if (time_q == 32'hFFFF_FFFF) begin
							outcome <= OUT_OVERFLOW;
							out_valid <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (ready_k && (!best_q.found || key < best_q.key)) begin
						best_q.found <= 1'b1;
						best_q.key <= key;
						best_q.id <= head.id;
						best_pos_q <= cnt_q;
					end
					if (cnt_q == SLOT_W'(TASK_SLOTS-1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == SLOT_W'(TASK_SLOTS-1)) begin
						state_q <= ST_IDLE;
						outcome <= best_q.found ? OUT_RAN : OUT_IDLE;
						ran_id <= best_q.found ? best_q.id : 16'd0;
						time_q <= time_q + 32'd1;
						out_valid <= 1'b1;
					end
				end
				ST_LOAD: begin
					if (cnt_q == tgt_q) begin
						valid_q[cnt_q] <= 1'b1;
					end
					if (cnt_q == SLOT_W'(TASK_SLOTS-1)) begin
						state_q <= ST_IDLE;
						outcome <= OUT_LOAD;
						out_valid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/ptts_cell.sv]
module ptts_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load_here,
	input  ptts_pkg::slot_t load_data,
	input  logic            run_here,
	input  logic            edf,
	input  ptts_pkg::slot_t prev,
	output ptts_pkg::slot_t slot
);
	import ptts_pkg::*;

	slot_t slot_q;
	slot_t nxt;

	always_comb begin
		nxt = prev;
		if (load_here) begin
			nxt = load_data;
		end else if (run_here) begin
			if (prev.remaining == 16'd1) begin
				nxt.release_t = sat_add32(prev.release_t, prev.period);
				if (edf) begin
					nxt.deadline = sat_add32(prev.deadline, prev.period);
				end
				nxt.remaining = prev.burst;
			end else begin
				nxt.remaining = prev.remaining - 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= nxt;
		end
	end

	assign slot = slot_q;
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import ptts_pkg::*;

	typedef struct {
		outcome_t    kind;
		logic [15:0] id;
		logic [31:0] stamp;
	} sched_res_t;

	typedef struct {
		bit          cmd;
		bit [3:0]    slot;
		bit [15:0]   id;
		bit [15:0]   burst;
		bit [15:0]   period;
		bit          typed;
		outcome_t    x_kind;
		bit [15:0]   x_id;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [3:0]  slot_index;
	logic [15:0] task_id;
	logic [15:0] burst_length;
	logic [15:0] period_length;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  outcome;
	logic [15:0] ran_id;
	logic [31:0] tick_time;

	bit          m_valid  [TASK_SLOTS];
	bit [15:0]   m_id     [TASK_SLOTS];
	bit [15:0]   m_burst  [TASK_SLOTS];
	bit [15:0]   m_period [TASK_SLOTS];
	bit [15:0]   m_left   [TASK_SLOTS];
	bit [31:0]   m_rel    [TASK_SLOTS];
	bit [31:0]   m_dl     [TASK_SLOTS];
	bit [31:0]   m_now;
	bit          m_edf;

	sched_res_t  pending_res[$];
	int          fails;
	bit          jitter_on;

	periodic_task_tick_scheduler uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.slot_index(slot_index), .task_id(task_id), .burst_length(burst_length),
		.period_length(period_length), .out_valid(out_valid), .out_ready(out_ready),
		.outcome(outcome), .ran_id(ran_id), .tick_time(tick_time)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic bit [31:0] clamp_sum(input bit [31:0] a, input bit [15:0] b);
		bit [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic sched_res_t schedule_beat(input plan_row_t r);
		sched_res_t res;
		int best;
		res.stamp = m_now;
		res.id = 16'd0;
		if (!r.cmd) begin
			m_valid[r.slot]  = 1'b1;
			m_id[r.slot]     = r.id;
			m_burst[r.slot]  = r.burst;
			m_period[r.slot] = r.period;
			m_left[r.slot]   = r.burst;
			m_rel[r.slot]    = 32'd0;
			m_dl[r.slot]     = {16'd0, r.period};
			res.kind = OUT_LOAD;
		end else if (m_now == 32'hFFFF_FFFF) begin
			res.kind = OUT_OVERFLOW;
		end else begin
			best = -1;
			for (int k = 0; k < TASK_SLOTS; k++) begin
				if (!m_valid[k] || m_rel[k] > m_now || m_left[k] == 16'd0)
					continue;
				if (best < 0)
					best = k;
				else if (m_edf ? (m_dl[k] < m_dl[best]) : (m_period[k] < m_period[best]))
					best = k;
			end
			if (best >= 0) begin
				res.kind = OUT_RAN;
				res.id = m_id[best];
				m_left[best]--;
				if (m_left[best] == 16'd0) begin
					m_rel[best] = clamp_sum(m_rel[best], m_period[best]);
					if (m_edf)
						m_dl[best] = clamp_sum(m_dl[best], m_period[best]);
					m_left[best] = m_burst[best];
				end
			end else begin
				res.kind = OUT_IDLE;
			end
			m_now++;
		end
		return res;
	endfunction

	task automatic send_beat(input plan_row_t r);
		int gap;
		sched_res_t res;
		gap = 0;
		while (jitter_on && $urandom_range(99) < 36)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = r.cmd;
		slot_index = r.slot;
		task_id = r.id;
		burst_length = r.burst;
		period_length = r.period;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = schedule_beat(r);
		if (r.typed) begin
			res.kind = r.x_kind;
			res.id = r.x_id;
		end
		pending_res.push_back(res);
		@(negedge clk);
	endtask

	task automatic set_policy(input bit edf);
		in_valid = 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = edf;
		@(negedge clk);
		cfg_we = 1'b0;
		m_edf = edf;
	endtask

	function automatic plan_row_t rand_row();
		plan_row_t r;
		r.typed = 1'b0;
		r.x_kind = OUT_LOAD;
		r.x_id = 16'd0;
		r.cmd = ($urandom_range(99) >= 25);
		r.slot = $urandom_range(15);
		r.id = $urandom_range(65535);
		r.burst = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(4, 1);
		r.period = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(20, 1);
		return r;
	endfunction

	always @(negedge clk)
		out_ready <= jitter_on ? ($urandom_range(99) >= 36) : 1'b1;

	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				$display("%t: unexpected beat outcome=%0d ran_id=%h tick_time=%0d",
					$time, outcome, ran_id, tick_time);
				fails++;
			end else begin
				e = pending_res.pop_front();
				if (outcome !== e.kind) begin
					$display("%t: outcome expected %0d actual %0d", $time, e.kind, outcome);
					fails++;
				end
				if (ran_id !== e.id) begin
					$display("%t: ran_id expected %h actual %h", $time, e.id, ran_id);
					fails++;
				end
				if (tick_time !== e.stamp) begin
					$display("%t: tick_time expected %0d actual %0d",
						$time, e.stamp, tick_time);
					fails++;
				end
			end
		end
	end

	plan_row_t plan[] = '{
		'{1, 0, 16'h0000, 16'd1, 16'd1, 1, OUT_IDLE, 16'h0000},
		'{0, 0, 16'hFFFF, 16'd2, 16'd5, 1, OUT_LOAD, 16'h0000},
		'{0, 15, 16'h0000, 16'd1, 16'hFFFF, 1, OUT_LOAD, 16'h0000},
		'{0, 7, 16'h1234, 16'd1, 16'd5, 1, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 1, OUT_RAN, 16'hFFFF},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{0, 0, 16'hAAAA, 16'hFFFF, 16'd1, 1, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{0, 0, 16'h5555, 16'd1, 16'd3, 1, OUT_LOAD, 16'h0000},
		'{0, 3, 16'h0F0F, 16'd1, 16'd3, 1, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000},
		'{1, 0, 16'h0000, 16'd1, 16'd1, 0, OUT_LOAD, 16'h0000}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		slot_index = 4'd0;
		task_id = 16'd0;
		burst_length = 16'd1;
		period_length = 16'd1;
		out_ready = 1'b0;
		fails = 0;
		jitter_on = 1'b1;
		m_now = 32'd0;
		m_edf = 1'b0;
		for (int k = 0; k < TASK_SLOTS; k++)
			m_valid[k] = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_beat(plan[i]);

		for (int ph = 0; ph < 6; ph++) begin
			set_policy(ph % 2 == 0);
			jitter_on = (ph != 2);
			for (int n = 0; n < 72; n++)
				send_beat(rand_row());
		end
		set_policy(1'b0);
		jitter_on = 1'b1;
		for (int n = 0; n < 10; n++)
			send_beat(rand_row());

		in_valid = 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

[sim.f]
design/ptts_pkg.sv
design/ptts_cell.sv
design/periodic_task_tick_scheduler.sv
verif/tb_top.sv
